### hw/rtl/tlip_pkg.sv
// Shared types, widths and codes for the tensor leg index permuter.
// No dependencies; imported by every module of the block.
`default_nettype none

package tlip_pkg;

  localparam int SITES     = 8;
  localparam int SLOT_W    = $clog2(SITES);
  localparam int IDX_W     = 16;
  localparam int VAL_W     = 64;
  localparam int SIZE_W    = 17;
  localparam int CNT_W     = 4;
  localparam int ORDER_W   = 24;
  localparam int CFG_W     = 24;
  localparam int REG_IDX_W = 2;
  localparam int DIM_W     = 17;
  localparam int RECIP_W   = 32;
  localparam int ST_W      = 2;
  localparam int LATENCY   = 3 * SITES + 2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_SIZE  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_MATRIX_SIZE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SITE_COUNT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SITE_ORDER  = 2'd2;

  localparam logic [SIZE_W-1:0]  SIZE_MAX    = SIZE_W'(1) << IDX_W;
  localparam logic [SIZE_W-1:0]  POW_SAT     = SIZE_MAX + SIZE_W'(1);
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(1);
  localparam logic [CNT_W-1:0]   COUNT_RESET = CNT_W'(1);
  localparam logic [ORDER_W-1:0] ORDER_RESET = 24'hFAC688;

  typedef logic [IDX_W-1:0] tlip_digit_t;

  typedef struct packed {
    logic [ST_W-1:0]               status;
    logic [VAL_W-1:0]              value;
    logic [IDX_W-1:0]              row_work;
    logic [IDX_W-1:0]              col_work;
    tlip_digit_t [SITES-1:0]       row_dig;
    tlip_digit_t [SITES-1:0]       col_dig;
  } tlip_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]   dim;
    logic [RECIP_W-1:0] recip;
    logic               size_bad;
  } tlip_dim_t;

  typedef struct packed {
    logic [DIM_W-1:0]   dim;
    logic [RECIP_W-1:0] recip;
    logic [CNT_W-1:0]   sites;
    logic [ORDER_W-1:0] order;
  } tlip_ctx_t;

endpackage

`default_nettype wire

### hw/rtl/tensor_leg_index_permuter.sv
// Top level of the tensor leg index permuter: config registers, input stage,
// digit and reassembly pipelines, output register. Uses tlip_pkg and submodules.
//
//   port group   direction  handshake          words
//   in_*         in         start / busy       row, column, value
//   out_*        out        out_strobe         permuted row, column, value, status
//   cfg_*        in         cfg_we             size, site count, site order
//
// One word enters per cycle while busy is low; each result passes through the input
// register, eight two-stage digit units, eight reassembly stages and the output register.
// Any config write runs the dimension sequencer (bisection with one shared
// multiplier, then a 32-step divider), holding busy high while it runs.
// Synchronous reset loads the default config and its derived values directly.
// Results are never held off; the pipeline advances every cycle.
`default_nettype none

module tensor_leg_index_permuter import tlip_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [IDX_W-1:0]     in_row_index,
  input  wire logic [IDX_W-1:0]     in_col_index,
  input  wire logic [VAL_W-1:0]     in_value_word,
  output logic                      out_strobe,
  output logic [IDX_W-1:0]          out_permuted_row,
  output logic [IDX_W-1:0]          out_permuted_col,
  output logic [VAL_W-1:0]          out_value_out,
  output logic [ST_W-1:0]           out_status,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic [SIZE_W-1:0]  matrix_size_r;
  logic [CNT_W-1:0]   site_count_r;
  logic [ORDER_W-1:0] site_order_r;

  tlip_dim_t          dim;
  tlip_ctx_t          ctx;
  logic               dim_busy;
  logic               accept;

  logic               in_vld_r;
  tlip_item_t         in_item_r;
  logic [ST_W-1:0]    in_status;

  logic               dig_vld  [SITES+1];
  tlip_item_t         dig_item [SITES+1];
  logic               hz_vld   [SITES+1];
  tlip_item_t         hz_item  [SITES+1];
  tlip_item_t         hz_head;

  logic               out_strobe_r;
  logic [IDX_W-1:0]   out_row_r;
  logic [IDX_W-1:0]   out_col_r;
  logic [VAL_W-1:0]   out_value_r;
  logic [ST_W-1:0]    out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r <= SIZE_RESET;
      site_count_r  <= COUNT_RESET;
      site_order_r  <= ORDER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATRIX_SIZE: matrix_size_r <= cfg_wdata[SIZE_W-1:0];
        REG_SITE_COUNT:  site_count_r  <= cfg_wdata[CNT_W-1:0];
        REG_SITE_ORDER:  site_order_r  <= cfg_wdata[ORDER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tlip_dim_unit u_dim (
    .clk         (clk),
    .rst_n       (rst_n),
    .kick        (cfg_we),
    .matrix_size (matrix_size_r),
    .site_count  (site_count_r),
    .dim_o       (dim),
    .busy        (dim_busy)
  );

  assign ctx.dim   = dim.dim;
  assign ctx.recip = dim.recip;
  assign ctx.sites = site_count_r;
  assign ctx.order = site_order_r;

  assign busy   = dim_busy || cfg_we;
  assign accept = start && !busy;

  always_comb begin
    if (dim.size_bad) begin
      in_status = ST_SIZE;
    end else if (SIZE_W'(in_row_index) >= matrix_size_r ||
                 SIZE_W'(in_col_index) >= matrix_size_r) begin
      in_status = ST_RANGE;
    end else begin
      in_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r.status   <= in_status;
    in_item_r.value    <= in_value_word;
    in_item_r.row_work <= in_row_index;
    in_item_r.col_work <= in_col_index;
    in_item_r.row_dig  <= '0;
    in_item_r.col_dig  <= '0;
  end

  assign dig_vld[0]  = in_vld_r;
  assign dig_item[0] = in_item_r;

  for (genvar g = 0; g < SITES; g++) begin : g_digit
    tlip_digit_stage u_digit (
      .clk    (clk),
      .rst_n  (rst_n),
      .slot   (SLOT_W'(g)),
      .ctx    (ctx),
      .vld_i  (dig_vld[g]),
      .item_i (dig_item[g]),
      .vld_o  (dig_vld[g+1]),
      .item_o (dig_item[g+1])
    );
  end

  always_comb begin
    hz_head          = dig_item[SITES];
    hz_head.row_work = '0;
    hz_head.col_work = '0;
  end
  assign hz_item[0] = hz_head;
  assign hz_vld[0]  = dig_vld[SITES];

  for (genvar g = 0; g < SITES; g++) begin : g_horner
    tlip_horner_stage u_horner (
      .clk    (clk),
      .rst_n  (rst_n),
      .slot   (SLOT_W'(SITES - 1 - g)),
      .ctx    (ctx),
      .vld_i  (hz_vld[g]),
      .item_i (hz_item[g]),
      .vld_o  (hz_vld[g+1]),
      .item_o (hz_item[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= hz_vld[SITES];
    end
  end

  always_ff @(posedge clk) begin
    out_row_r    <= (hz_item[SITES].status == ST_OK) ? hz_item[SITES].row_work : '0;
    out_col_r    <= (hz_item[SITES].status == ST_OK) ? hz_item[SITES].col_work : '0;
    out_value_r  <= hz_item[SITES].value;
    out_status_r <= hz_item[SITES].status;
  end

  assign out_strobe       = out_strobe_r;
  assign out_permuted_row = out_row_r;
  assign out_permuted_col = out_col_r;
  assign out_value_out    = out_value_r;
  assign out_status       = out_status_r;

  a_word_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_strobe)
    else $error("accepted word did not emerge at the expected cycle");

  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != ST_OK |-> out_permuted_row == '0 && out_permuted_col == '0)
    else $error("error result carries nonzero indices");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("config write did not start dimension sequencer");

endmodule

`default_nettype wire

### hw/rtl/tlip_dim_unit.sv
// Local dimension sequencer: bisection search for d with a shared multiplier,
// exact power check and a restoring divider for the reciprocal. Uses tlip_pkg.
`default_nettype none

module tlip_dim_unit import tlip_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              kick,
  input  wire logic [SIZE_W-1:0] matrix_size,
  input  wire logic [CNT_W-1:0]  site_count,
  output tlip_dim_t              dim_o,
  output logic                   busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MID   = 3'd2;
  localparam logic [2:0] S_POW   = 3'd3;
  localparam logic [2:0] S_RECIP = 3'd4;

  localparam int POWP_W = SIZE_W + DIM_W;
  localparam int BIT_W  = $clog2(RECIP_W);

  logic [2:0]         state_r, state_nxt;
  logic [DIM_W-1:0]   lo_r, lo_nxt;
  logic [DIM_W-1:0]   hi_r, hi_nxt;
  logic [DIM_W-1:0]   base_r, base_nxt;
  logic [SIZE_W-1:0]  pow_r, pow_nxt;
  logic [CNT_W-1:0]   step_r, step_nxt;
  logic               last_r, last_nxt;
  logic [DIM_W-1:0]   rem_r, rem_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [DIM_W-1:0]   dim_r, dim_nxt;
  logic [RECIP_W-1:0] recip_r, recip_nxt;
  logic               bad_r, bad_nxt;

  logic [POWP_W-1:0]  pow_prod;
  logic [DIM_W:0]     rem_shift;
  logic               rem_ge;

  assign pow_prod  = POWP_W'(pow_r) * POWP_W'(base_r);
  assign rem_shift = {rem_r, 1'b1};
  assign rem_ge    = rem_shift >= (DIM_W + 1)'(dim_r);

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    base_nxt  = base_r;
    pow_nxt   = pow_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    dim_nxt   = dim_r;
    recip_nxt = recip_r;
    bad_nxt   = bad_r;
    unique case (state_r)
      S_IDLE: begin
      end
      S_CHECK: begin
        if (site_count == '0 || site_count > CNT_W'(SITES) || matrix_size > SIZE_MAX) begin
          bad_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else if (matrix_size == '0) begin
          bad_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          lo_nxt    = DIM_W'(1);
          hi_nxt    = matrix_size;
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        if (lo_r < hi_r) begin
          base_nxt = lo_r + ((hi_r - lo_r) >> 1);
          last_nxt = 1'b0;
        end else begin
          base_nxt = lo_r;
          last_nxt = 1'b1;
        end
        pow_nxt   = SIZE_W'(1);
        step_nxt  = '0;
        state_nxt = S_POW;
      end
      S_POW: begin
        if (step_r == site_count || pow_r > SIZE_MAX) begin
          if (last_r) begin
            dim_nxt = base_r;
            bad_nxt = (pow_r != matrix_size);
            if (pow_r != matrix_size) begin
              state_nxt = S_IDLE;
            end else begin
              rem_nxt   = '0;
              bit_nxt   = '0;
              recip_nxt = '0;
              state_nxt = S_RECIP;
            end
          end else begin
            if (pow_r >= matrix_size) begin
              hi_nxt = base_r;
            end else begin
              lo_nxt = base_r + DIM_W'(1);
            end
            state_nxt = S_MID;
          end
        end else begin
          pow_nxt  = (pow_prod > POWP_W'(SIZE_MAX)) ? POW_SAT : pow_prod[SIZE_W-1:0];
          step_nxt = step_r + CNT_W'(1);
        end
      end
      S_RECIP: begin
        rem_nxt   = rem_ge ? DIM_W'(rem_shift - (DIM_W + 1)'(dim_r)) : rem_shift[DIM_W-1:0];
        recip_nxt = {recip_r[RECIP_W-2:0], rem_ge};
        bit_nxt   = bit_r + BIT_W'(1);
        if (bit_r == BIT_W'(RECIP_W - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (kick) begin
      state_nxt = S_CHECK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dim_r   <= DIM_W'(1);
      recip_r <= '1;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dim_r   <= dim_nxt;
      recip_r <= recip_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    base_r <= base_nxt;
    pow_r  <= pow_nxt;
    step_r <= step_nxt;
    last_r <= last_nxt;
    rem_r  <= rem_nxt;
    bit_r  <= bit_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign dim_o.dim      = dim_r;
  assign dim_o.recip    = recip_r;
  assign dim_o.size_bad = bad_r;

  a_recip_nonzero_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RECIP |-> dim_r != '0)
    else $error("divider running with zero divisor");

  a_bisect_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MID |-> lo_r <= hi_r)
    else $error("bisection bounds crossed");

  a_pow_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POW |-> step_r <= site_count)
    else $error("power loop ran past site count");

endmodule

`default_nettype wire

### hw/rtl/tlip_digit_stage.sv
// One digit extraction step for both indices: reciprocal multiply, then
// remainder with a single correction. Two register stages. Uses tlip_pkg.
`default_nettype none

module tlip_digit_stage import tlip_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire tlip_ctx_t         ctx,
  input  wire logic              vld_i,
  input  wire tlip_item_t        item_i,
  output logic                   vld_o,
  output tlip_item_t             item_o
);

  localparam int PROD_W = IDX_W + RECIP_W;
  localparam int MUL_W  = IDX_W + DIM_W;

  logic [PROD_W-1:0] row_est;
  logic [PROD_W-1:0] col_est;

  logic              vld_a_r;
  tlip_item_t        item_a_r;
  logic [IDX_W-1:0]  rq_a_r;
  logic [IDX_W-1:0]  cq_a_r;

  logic [MUL_W-1:0]  row_back;
  logic [MUL_W-1:0]  col_back;
  logic [IDX_W-1:0]  row_rem;
  logic [IDX_W-1:0]  col_rem;
  logic              row_ge;
  logic              col_ge;
  tlip_item_t        item_nxt;

  logic              vld_r;
  tlip_item_t        item_r;

  assign row_est = PROD_W'(item_i.row_work) * PROD_W'(ctx.recip);
  assign col_est = PROD_W'(item_i.col_work) * PROD_W'(ctx.recip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    item_a_r <= item_i;
    rq_a_r   <= row_est[PROD_W-1 -: IDX_W];
    cq_a_r   <= col_est[PROD_W-1 -: IDX_W];
  end

  assign row_back = MUL_W'(rq_a_r) * MUL_W'(ctx.dim);
  assign col_back = MUL_W'(cq_a_r) * MUL_W'(ctx.dim);
  assign row_rem  = item_a_r.row_work - row_back[IDX_W-1:0];
  assign col_rem  = item_a_r.col_work - col_back[IDX_W-1:0];
  assign row_ge   = DIM_W'(row_rem) >= ctx.dim;
  assign col_ge   = DIM_W'(col_rem) >= ctx.dim;

  always_comb begin
    item_nxt = item_a_r;
    item_nxt.row_dig[slot] = row_ge ? row_rem - ctx.dim[IDX_W-1:0] : row_rem;
    item_nxt.col_dig[slot] = col_ge ? col_rem - ctx.dim[IDX_W-1:0] : col_rem;
    item_nxt.row_work      = row_ge ? rq_a_r + IDX_W'(1) : rq_a_r;
    item_nxt.col_work      = col_ge ? cq_a_r + IDX_W'(1) : cq_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

`default_nettype wire

### hw/rtl/tlip_horner_stage.sv
// One reassembly step for both indices: acc = acc * d + selected digit,
// skipped for slots at or beyond the site count. Uses tlip_pkg.
`default_nettype none

module tlip_horner_stage import tlip_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire tlip_ctx_t         ctx,
  input  wire logic              vld_i,
  input  wire tlip_item_t        item_i,
  output logic                   vld_o,
  output tlip_item_t             item_o
);

  localparam int MUL_W = IDX_W + DIM_W;

  logic [SLOT_W-1:0] src;
  logic              active;
  logic              src_ok;
  logic [IDX_W-1:0]  row_pick;
  logic [IDX_W-1:0]  col_pick;
  logic [MUL_W-1:0]  row_prod;
  logic [MUL_W-1:0]  col_prod;
  tlip_item_t        item_nxt;

  logic              vld_r;
  tlip_item_t        item_r;

  assign src      = ctx.order[slot * SLOT_W +: SLOT_W];
  assign active   = CNT_W'(slot) < ctx.sites;
  assign src_ok   = CNT_W'(src) < ctx.sites;
  assign row_pick = src_ok ? item_i.row_dig[src] : '0;
  assign col_pick = src_ok ? item_i.col_dig[src] : '0;
  assign row_prod = MUL_W'(item_i.row_work) * MUL_W'(ctx.dim);
  assign col_prod = MUL_W'(item_i.col_work) * MUL_W'(ctx.dim);

  always_comb begin
    item_nxt = item_i;
    if (active) begin
      item_nxt.row_work = row_prod[IDX_W-1:0] + row_pick;
      item_nxt.col_work = col_prod[IDX_W-1:0] + col_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign vld_o  = vld_r;
  assign item_o = item_r;

endmodule

`default_nettype wire

### test/tb_tensor_leg_index_permuter.sv
// Self-checking testbench for tensor_leg_index_permuter: base-d digit permutation
// of row and column indices, with status checks, under random start gaps.
// Depends on tlip_pkg and the tensor_leg_index_permuter RTL only.
module tb_tensor_leg_index_permuter;
  import tlip_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic [ST_W-1:0]  status;
  } entry_t;

  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam longint unsigned SAT_CAP = 64'h100000;
  localparam logic [ORDER_W-1:0] ORDER_ROTATE3 = 24'h000042;
  localparam logic [ORDER_W-1:0] ORDER_SWAP2 = 24'h000001;
  localparam logic [ORDER_W-1:0] ORDER_REVERSE8 = 24'h053977;
  localparam logic [ORDER_W-1:0] ORDER_DUP3 = 24'h000005;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [IDX_W-1:0]   in_row_index = '0;
  logic [IDX_W-1:0]   in_col_index = '0;
  logic [VAL_W-1:0]   in_value_word = '0;
  logic               out_strobe;
  logic [IDX_W-1:0]   out_permuted_row;
  logic [IDX_W-1:0]   out_permuted_col;
  logic [VAL_W-1:0]   out_value_out;
  logic [ST_W-1:0]    out_status;
  logic               cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  logic [SIZE_W-1:0]  size_reg = SIZE_RESET;
  logic [CNT_W-1:0]   count_reg = COUNT_RESET;
  logic [ORDER_W-1:0] order_reg = ORDER_RESET;

  entry_t pending_q[$];
  int     fail_count = 0;
  bit     burst_mode = 1'b0;

  tensor_leg_index_permuter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_value_word    (in_value_word),
    .out_strobe       (out_strobe),
    .out_permuted_row (out_permuted_row),
    .out_permuted_col (out_permuted_col),
    .out_value_out    (out_value_out),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned sat_power(longint unsigned d, longint unsigned n);
    longint unsigned r = 1;
    for (longint unsigned i = 0; i < n; i++) begin
      r = r * d;
      if (r > SAT_CAP) return SAT_CAP + 1;
    end
    return r;
  endfunction

  function automatic longint unsigned dim_for_size(longint unsigned m, longint unsigned n);
    longint unsigned lo = 1;
    longint unsigned hi = m;
    longint unsigned mid;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (sat_power(mid, n) >= m) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic logic [IDX_W-1:0] permute_digits(longint unsigned idx,
                                                      longint unsigned d,
                                                      longint unsigned n);
    longint unsigned digit[SITES];
    longint unsigned rest = idx;
    longint unsigned acc = 0;
    longint unsigned src;
    for (int k = 0; k < n; k++) begin
      digit[k] = rest % d;
      rest = rest / d;
    end
    for (int k = int'(n); k > 0; k--) begin
      src = (longint'(order_reg) >> (3 * (k - 1))) & 7;
      acc = acc * d + ((src < n) ? digit[src] : 0);
    end
    return acc[IDX_W-1:0];
  endfunction

  function automatic entry_t permute_entry(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                           logic [VAL_W-1:0] val);
    longint unsigned m = 64'(size_reg);
    longint unsigned n = 64'(count_reg);
    longint unsigned d;
    entry_t e;
    e.row = '0;
    e.col = '0;
    e.value = val;
    e.status = ST_OK;
    if (n == 0 || n > SITES || m > (64'd1 << IDX_W)) begin
      e.status = ST_SIZE;
    end else if (m == 0) begin
      e.status = ST_RANGE;
    end else begin
      d = dim_for_size(m, n);
      if (sat_power(d, n) != m) begin
        e.status = ST_SIZE;
      end else if (row >= m || col >= m) begin
        e.status = ST_RANGE;
      end else begin
        e.row = permute_digits(64'(row), d, n);
        e.col = permute_digits(64'(col), d, n);
      end
    end
    return e;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    entry_t e;
    if (rst_n && out_strobe) begin
      if (pending_q.size() == 0) begin
        note_failure($sformatf("unexpected word: row %h col %h value %h status %0d",
                               out_permuted_row, out_permuted_col, out_value_out,
                               out_status));
      end else begin
        e = pending_q.pop_front();
        if (out_permuted_row !== e.row || out_permuted_col !== e.col ||
            out_value_out !== e.value || out_status !== e.status)
          note_failure($sformatf(
            "mismatch: exp row %h col %h value %h status %0d, got %h %h %h %0d",
            e.row, e.col, e.value, e.status, out_permuted_row, out_permuted_col,
            out_value_out, out_status));
      end
    end
  end

  task automatic send_word(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                           input logic [VAL_W-1:0] val);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    in_row_index = row;
    in_col_index = col;
    in_value_word = val;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.insert(pending_q.size(), permute_entry(row, col, val));
  endtask

  task automatic drain_pipe();
    @(negedge clk);
    start = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_MATRIX_SIZE: size_reg = data[SIZE_W-1:0];
      REG_SITE_COUNT:  count_reg = data[CNT_W-1:0];
      REG_SITE_ORDER:  order_reg = data[ORDER_W-1:0];
      default: ;
    endcase
    // let the dimension sequencer raise busy, then wait it out
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic configure(input logic [SIZE_W-1:0] size, input logic [CNT_W-1:0] count,
                           input logic [ORDER_W-1:0] order);
    drain_pipe();
    write_reg(REG_MATRIX_SIZE, {7'($urandom), size});
    write_reg(REG_SITE_COUNT, {20'($urandom), count});
    write_reg(REG_SITE_ORDER, order);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_config();
    send_word(16'h0000, 16'h0000, 64'h0);
    send_word(16'h0000, 16'h0000, {VAL_W{1'b1}});
    send_word(16'h0001, 16'h0000, 64'h8000_0000_0000_0001);
    send_word(16'h0000, 16'hFFFF, rand_value());
    send_word(16'hFFFF, 16'hFFFF, rand_value());
  endtask

  task automatic test_permutation();
    configure(17'd8, 4'd3, ORDER_ROTATE3);
    send_word(16'd0, 16'd7, rand_value());
    send_word(16'd5, 16'd3, rand_value());
    send_word(16'd7, 16'd7, rand_value());
    send_word(16'd8, 16'd0, rand_value());
    configure(17'd65536, 4'd8, ORDER_REVERSE8);
    send_word(16'h1234, 16'hFFFF, rand_value());
    send_word(16'h0000, 16'hA5A5, rand_value());
    configure(17'd65536, 4'd1, ORDER_RESET);
    send_word(16'hFFFF, 16'h0000, rand_value());
    configure(17'd256, 4'd2, ORDER_SWAP2);
    send_word(16'h12AB, 16'h00FF, rand_value());
    send_word(16'h0100, 16'h00FF, rand_value());
  endtask

  task automatic test_size_errors();
    configure(17'd16, 4'd0, ORDER_RESET);
    send_word(16'd1, 16'd2, rand_value());
    configure(17'd16, 4'd9, ORDER_RESET);
    send_word(16'd1, 16'd2, rand_value());
    configure(17'd16, 4'd15, ORDER_RESET);
    send_word(16'd1, 16'd2, rand_value());
    configure(17'd65537, 4'd1, ORDER_RESET);
    send_word(16'd1, 16'd2, rand_value());
    configure(17'd131071, 4'd2, ORDER_RESET);
    send_word(16'd1, 16'd2, rand_value());
    // size check wins over the range check
    configure(17'd10, 4'd2, ORDER_SWAP2);
    send_word(16'hFFFF, 16'd2, rand_value());
    configure(17'd0, 4'd3, ORDER_RESET);
    send_word(16'd0, 16'd0, rand_value());
    configure(17'd1, 4'd4, ORDER_RESET);
    send_word(16'd0, 16'd0, rand_value());
    configure(17'd27, 4'd3, ORDER_DUP3);
    send_word(16'd26, 16'd14, rand_value());
    drain_pipe();
    write_reg(REG_SPARE, CFG_W'($urandom));
    send_word(16'd5, 16'd11, rand_value());
  endtask

  task automatic test_random_streams();
    longint unsigned n;
    longint unsigned d;
    longint unsigned dmax;
    longint unsigned m;
    int slot;
    int src;
    int fields[SITES];
    logic [ORDER_W-1:0] order;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    for (int phase = 0; phase < 30; phase++) begin
      n = 64'($urandom_range(1, SITES));
      if (n == 1) begin
        m = 64'($urandom_range(1, 65536));
      end else begin
        dmax = 1;
        while (sat_power(dmax + 1, n) <= 65536) dmax++;
        d = 64'($urandom_range(1, 32'(dmax)));
        m = sat_power(d, n);
      end
      for (int k = 0; k < SITES; k++) fields[k] = k;
      for (int k = int'(n) - 1; k > 0; k--) begin
        slot = $urandom_range(0, k);
        src = fields[k];
        fields[k] = fields[slot];
        fields[slot] = src;
      end
      order = ORDER_W'($urandom);
      for (int k = 0; k < n; k++) order[3*k +: 3] = 3'(fields[k]);
      case ($urandom_range(0, 9))
        0: configure(SIZE_W'($urandom), CNT_W'($urandom), ORDER_W'($urandom));
        1: configure(SIZE_W'(m), CNT_W'(n), ORDER_W'($urandom));
        default: configure(SIZE_W'(m), CNT_W'(n), order);
      endcase
      burst_mode = ($urandom_range(0, 3) == 0);
      m = 64'(size_reg);
      repeat (35) begin
        row = IDX_W'($urandom);
        col = IDX_W'($urandom);
        if (m >= 1 && m <= 65536) begin
          case ($urandom_range(0, 9))
            0: ;
            1: begin
              if (m < 65536) begin
                if ($urandom_range(0, 1)) row = IDX_W'($urandom_range(32'(m), 65535));
                else col = IDX_W'($urandom_range(32'(m), 65535));
              end
            end
            default: begin
              row = IDX_W'($urandom_range(0, 32'(m - 1)));
              col = IDX_W'($urandom_range(0, 32'(m - 1)));
            end
          endcase
        end
        send_word(row, col, rand_value());
      end
      burst_mode = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_config();
    test_permutation();
    test_size_errors();
    test_random_streams();
    drain_pipe();
    if (fail_count == 0) begin
      $display("tb_tensor_leg_index_permuter: done, clean");
    end else begin
      $display("tb_tensor_leg_index_permuter: done, errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_tensor_leg_index_permuter: done, errors");
    $finish;
  end

endmodule
